@@ hdl/eti_pkg.sv @@
// eti_pkg: shared constants, item type and helper functions for the
// escape-time fractal iterator. No dependencies.
package eti_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int COUNT_WIDTH = 16;
   localparam int DATA_W      = 32;
   localparam int LIMIT_W     = 16;
   localparam int OUT_W       = 16;
   localparam int MODE_W      = 2;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CELTIC = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_RE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_IM   = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // |z|^2 <= 4 in 2*FRAC_BITS fraction bits; never fails once 4 is out of reach
   localparam bit ESC_ALWAYS = (2 * FRAC_BITS + 2 >= PROD_W);
   localparam logic [PROD_W-1:0] ESC_THRESH =
      ESC_ALWAYS ? '0 : (PROD_W'(1) << (2 * FRAC_BITS + 2));

   typedef struct packed {
      logic                     celtic;
      logic signed [DATA_W-1:0] point_re;
      logic signed [DATA_W-1:0] point_im;
      logic signed [DATA_W-1:0] offset_re;
      logic signed [DATA_W-1:0] offset_im;
      logic [COUNT_WIDTH-1:0]   limit;
   } item_type;

   function automatic logic [COUNT_WIDTH-1:0] clamp_limit(input logic [LIMIT_W-1:0] lim);
      logic [47:0] wide;
      wide = 48'(lim);
      if (wide > 48'(COUNT_MAX))
         return COUNT_MAX;
      return wide[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
      lo = -hi - PROD_W'(1);
      if (v > hi)
         return {1'b0, {(DATA_W-1){1'b1}}};
      if (v < lo)
         return {1'b1, {(DATA_W-1){1'b0}}};
      return v[DATA_W-1:0];
   endfunction

endpackage

@@ hdl/eti_front.sv @@
// eti_front: control registers and request intake; turns a request into a
// work item (offset and mode resolved, limit clamped). Uses eti_pkg.
module eti_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [eti_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [eti_pkg::DATA_W-1:0]   req_point_re,
   input  logic signed [eti_pkg::DATA_W-1:0]   req_point_im,
   input  logic                                csr_write_en,
   input  logic [eti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [eti_pkg::DATA_W-1:0]          csr_wdata,
   input  logic                                q_full,
   output logic                                q_push,
   output eti_pkg::item_type                   q_item
);

   logic [eti_pkg::LIMIT_W-1:0]        limit_ff;
   logic signed [eti_pkg::DATA_W-1:0]  julia_re_ff;
   logic signed [eti_pkg::DATA_W-1:0]  julia_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= eti_pkg::LIMIT_RESET;
         julia_re_ff <= '0;
         julia_im_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            eti_pkg::CSR_ITER_LIMIT: limit_ff    <= csr_wdata[eti_pkg::LIMIT_W-1:0];
            eti_pkg::CSR_JULIA_RE:   julia_re_ff <= csr_wdata;
            eti_pkg::CSR_JULIA_IM:   julia_im_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy   = q_full;
   assign q_push = start && !q_full;

   always_comb begin
      q_item          = '0;
      q_item.celtic   = (req_mode == eti_pkg::MODE_CELTIC);
      q_item.point_re = req_point_re;
      q_item.point_im = req_point_im;
      q_item.limit    = eti_pkg::clamp_limit(limit_ff);
      // unused mode code runs as Mandelbrot
      if (req_mode == eti_pkg::MODE_JULIA) begin
         q_item.offset_re = julia_re_ff;
         q_item.offset_im = julia_im_ff;
      end else begin
         q_item.offset_re = req_point_re;
         q_item.offset_im = req_point_im;
      end
   end

endmodule

@@ hdl/eti_queue.sv @@
// eti_queue: short FIFO of work items between intake and the iteration
// engine. Uses eti_pkg.
module eti_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  eti_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output eti_pkg::item_type head_item
);

   eti_pkg::item_type                mem_ff [eti_pkg::QUEUE_DEPTH];
   logic [eti_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [eti_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [eti_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;

   assign full      = (cnt_ff == eti_pkg::QCNT_W'(eti_pkg::QUEUE_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == eti_pkg::QPTR_W'(eti_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == eti_pkg::QPTR_W'(eti_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)
         cnt_in = cnt_ff + 1'b1;
      else if (pop && !push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ hdl/eti_back.sv @@
// eti_back: iteration engine. Runs z = z^2 + offset, each iteration stepping through
// multiply, escape test and update states, and strobes the count. Uses eti_pkg.
module eti_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  eti_pkg::item_type             q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   output logic [eti_pkg::OUT_W-1:0]     rsp_iteration_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHK,
      ST_UPD
   } state_type;

   state_type                           state_ff, state_in;
   logic signed [eti_pkg::DATA_W-1:0]   zr_ff, zr_in;
   logic signed [eti_pkg::DATA_W-1:0]   zi_ff, zi_in;
   logic signed [eti_pkg::DATA_W-1:0]   off_re_ff, off_re_in;
   logic signed [eti_pkg::DATA_W-1:0]   off_im_ff, off_im_in;
   logic                                celtic_ff, celtic_in;
   logic [eti_pkg::COUNT_WIDTH-1:0]     limit_ff, limit_in;
   logic [eti_pkg::COUNT_WIDTH-1:0]     count_ff, count_in;
   logic signed [eti_pkg::PROD_W-1:0]   sq_re_ff, sq_re_in;
   logic signed [eti_pkg::PROD_W-1:0]   sq_im_ff, sq_im_in;
   logic signed [eti_pkg::PROD_W-1:0]   cross_ff, cross_in;
   logic signed [eti_pkg::PROD_W-1:0]   diff_ff, diff_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [eti_pkg::OUT_W-1:0]           rsp_count_ff, rsp_count_in;

   logic [eti_pkg::PROD_W-1:0]          mag;
   logic                                keep_going;
   logic signed [eti_pkg::PROD_W-1:0]   diff_abs;
   logic signed [eti_pkg::PROD_W-1:0]   re_sum;
   logic signed [eti_pkg::PROD_W-1:0]   im_sum;
   logic [47:0]                         count_wide;

   assign q_pop               = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

   always_comb begin
      // squares are never negative, so the sum fits unsigned
      mag        = $unsigned(sq_re_ff) + $unsigned(sq_im_ff);
      keep_going = (count_ff < limit_ff) && (eti_pkg::ESC_ALWAYS || mag <= eti_pkg::ESC_THRESH);
      diff_abs   = (celtic_ff && diff_ff < 0) ? -diff_ff : diff_ff;
      // floor shifts; the cross term shifts one less to double it
      re_sum     = (diff_abs >>> eti_pkg::FRAC_BITS) + eti_pkg::PROD_W'(off_re_ff);
      im_sum     = (cross_ff >>> (eti_pkg::FRAC_BITS - 1)) + eti_pkg::PROD_W'(off_im_ff);
      count_wide = 48'(count_ff);
   end

   always_comb begin
      state_in     = state_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      off_re_in    = off_re_ff;
      off_im_in    = off_im_ff;
      celtic_in    = celtic_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      sq_re_in     = sq_re_ff;
      sq_im_in     = sq_im_ff;
      cross_in     = cross_ff;
      diff_in      = diff_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               zr_in     = q_head.point_re;
               zi_in     = q_head.point_im;
               off_re_in = q_head.offset_re;
               off_im_in = q_head.offset_im;
               celtic_in = q_head.celtic;
               limit_in  = q_head.limit;
               count_in  = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            sq_re_in = zr_ff * zr_ff;
            sq_im_in = zi_ff * zi_ff;
            cross_in = zr_ff * zi_ff;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            diff_in = sq_re_ff - sq_im_ff;
            if (keep_going) begin
               state_in = ST_UPD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_wide[eti_pkg::OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         ST_UPD: begin
            zr_in    = eti_pkg::sat_data(re_sum);
            zi_in    = eti_pkg::sat_data(im_sum);
            count_in = count_ff + 1'b1;
            state_in = ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      off_re_ff    <= off_re_in;
      off_im_ff    <= off_im_in;
      celtic_ff    <= celtic_in;
      limit_ff     <= limit_in;
      count_ff     <= count_in;
      sq_re_ff     <= sq_re_in;
      sq_im_ff     <= sq_im_in;
      cross_ff     <= cross_in;
      diff_ff      <= diff_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

@@ hdl/escape_time_fractal_iterator.sv @@
// escape_time_fractal_iterator: top level; intake, item queue and iteration
// engine. Uses eti_pkg, eti_front, eti_queue, eti_back.
//
// Usage:
//   A point goes in when start is high and busy is low: req_mode,
//   req_point_re, req_point_im (signed, FRAC_BITS fraction bits).
//   Julia constant and iteration limit come from the csr_ write port and
//   are sampled when a point is taken; write them only while idle.
//   Each point gives one word: rsp_iteration_count, shown for one cycle
//   with rsp_valid high. The receiver cannot stall; words arrive in order.
//   Steps: an iteration runs multiply, escape test and update in turn;
//   a point that runs n iterations holds the engine for a load step,
//   the steps of each of its iterations, then a final multiply and test.
//   rsp_valid is registered from that final test. Points queue two deep
//   ahead of the engine; busy is high while that queue is full.
//   Reset (synchronous, active high) empties the queue, idles the engine
//   and restores limit 256 and a zero Julia constant.
module escape_time_fractal_iterator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [eti_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [eti_pkg::DATA_W-1:0]   req_point_re,
   input  logic signed [eti_pkg::DATA_W-1:0]   req_point_im,
   output logic                                rsp_valid,
   output logic [eti_pkg::OUT_W-1:0]           rsp_iteration_count,
   input  logic                                csr_write_en,
   input  logic [eti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [eti_pkg::DATA_W-1:0]          csr_wdata
);

   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   eti_pkg::item_type q_item;
   eti_pkg::item_type q_head;

   eti_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_point_re (req_point_re),
      .req_point_im (req_point_im),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_item       (q_item)
   );

   eti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head)
   );

   eti_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

@@ hdl/eti_checker.sv @@
// eti_checker: port-level assertions for escape_time_fractal_iterator,
// attached by bind. Uses eti_pkg for port widths.
module eti_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [eti_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [eti_pkg::DATA_W-1:0]   req_point_re,
   input  logic signed [eti_pkg::DATA_W-1:0]   req_point_im,
   input  logic                                rsp_valid,
   input  logic [eti_pkg::OUT_W-1:0]           rsp_iteration_count,
   input  logic                                csr_write_en,
   input  logic [eti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [eti_pkg::DATA_W-1:0]          csr_wdata
);

   // reset leaves nothing in flight
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("word or busy seen right after reset");

   // each point takes the engine through load, multiply and test states, so strobes never abut
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result words in consecutive cycles");

   // the queue only fills by taking points
   a_busy_needs_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted point");

endmodule

bind escape_time_fractal_iterator eti_checker u_eti_checker (.*);
